### rtl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants for the Go-Back-N link endpoint: event and
// result codes, widths, and the command passed from the front to the back.
// ----------------------------------------------------------------------------
package gbn_pkg;

   localparam int PORT_PAYLOAD_BITS = 32;
   localparam int AGE_BITS          = 24;
   localparam int SEQ_BITS          = 2;
   localparam int COUNT_BITS        = 3;
   localparam int SLOTS             = 4;
   localparam int CMD_DEPTH         = 2;
   localparam int CMD_PTR_BITS      = 1;
   localparam int CMD_FILL_BITS     = 2;

   localparam int DEF_WINDOW_SIZE   = 4;
   localparam int DEF_PAYLOAD_BITS  = 32;

   localparam logic [AGE_BITS-1:0] TIMEOUT_RESET = 24'd5000;
   localparam logic [AGE_BITS-1:0] AGE_MAX       = 24'hFFFFFF;
   localparam logic [SEQ_BITS-1:0] LAST_RX_RESET = 2'd3;

   typedef enum logic [1:0] {
      OP_ACK  = 2'd0,
      OP_DATA = 2'd1,
      OP_SEND = 2'd2,
      OP_TICK = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_SEND    = 3'd0,
      KIND_ACK     = 3'd1,
      KIND_DELIVER = 3'd2,
      KIND_REFUSED = 3'd3,
      KIND_DISCARD = 3'd4
   } kind_type;

   // What the back has to emit for one accepted event.
   typedef enum logic [1:0] {
      JOB_SINGLE  = 2'd0,
      JOB_DELIVER = 2'd1,
      JOB_RESEND  = 2'd2
   } job_type;

   typedef struct packed {
      job_type                                     job;
      kind_type                                    kind;
      logic [SEQ_BITS-1:0]                         seq;
      logic [PORT_PAYLOAD_BITS-1:0]                payload;
      logic [SEQ_BITS-1:0]                         head;
      logic [COUNT_BITS-1:0]                       count;
      logic [SLOTS-1:0][PORT_PAYLOAD_BITS-1:0]     slots;
   } cmd_type;

endpackage

### rtl/go_back_n_link_endpoint.sv
// ----------------------------------------------------------------------------
// go_back_n_link_endpoint
// One endpoint of a Go-Back-N link with sequence numbers modulo four.
//
//   Channel   Direction  Handshake                 Carries
//   req_      in         push / full               op, seq_num, payload
//   rsp_      out        empty / pop               kind, frame_seq,
//                                                  frame_payload, last
//   csr_      in         valid / ready             timeout_ticks
//
// An event is classified and the window state updated in the cycle it is
// transferred; any command it makes then waits in a two-entry command queue.
// The result stage emits one result a cycle while the consumer pops, and an
// event gives at most four results, the most for a timeout that resends a full
// window. The front stalls only when the command queue is full. Reset is
// synchronous; the configuration port never stalls.
// ----------------------------------------------------------------------------
module go_back_n_link_endpoint import gbn_pkg::*; #(
   parameter int WINDOW_SIZE  = DEF_WINDOW_SIZE,
   parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [1:0]                    req_op,
   input  logic [SEQ_BITS-1:0]           req_seq_num,
   input  logic [PORT_PAYLOAD_BITS-1:0]  req_payload,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [2:0]                    rsp_kind,
   output logic [SEQ_BITS-1:0]           rsp_frame_seq,
   output logic [PORT_PAYLOAD_BITS-1:0]  rsp_frame_payload,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [AGE_BITS-1:0]           csr_timeout_ticks
);

   logic    req_transfer;
   logic    csr_write;
   logic    cmd_push;
   cmd_type cmd_in;
   cmd_type cmd_out;
   logic    cmd_empty;
   logic    cmd_pop;

   assign csr_ready    = 1'b1;
   assign csr_write    = csr_valid && csr_ready;
   assign req_transfer = req_push && !req_full;

   gbn_front #(
      .WINDOW_SIZE  (WINDOW_SIZE),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .evt_valid   (req_transfer),
      .evt_op      (req_op),
      .evt_seq     (req_seq_num),
      .evt_payload (req_payload),
      .csr_write   (csr_write),
      .csr_data    (csr_timeout_ticks),
      .cmd_push    (cmd_push),
      .cmd_data    (cmd_in)
   );

   gbn_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out),
      .empty     (cmd_empty)
   );

   gbn_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_data          (cmd_out),
      .cmd_empty         (cmd_empty),
      .cmd_pop           (cmd_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_kind          (rsp_kind),
      .rsp_frame_seq     (rsp_frame_seq),
      .rsp_frame_payload (rsp_frame_payload),
      .rsp_last          (rsp_last)
   );

   // Acks, refusals and discards never carry a payload.
   a_no_payload : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_kind == KIND_ACK || rsp_kind == KIND_REFUSED ||
                      rsp_kind == KIND_DISCARD)) |-> (rsp_frame_payload == '0))
      else $error("payload on a result that carries none");

   // A delivery is always followed by its ack, so it is never the last result.
   a_deliver_not_last : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == KIND_DELIVER) |-> !rsp_last)
      else $error("delivery marked as the last result");

   // The command queue is not full and the result stage is empty straight after reset.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> (!req_full && rsp_empty))
      else $error("queues not empty after reset");

endmodule

### rtl/gbn_front.sv
// ----------------------------------------------------------------------------
// gbn_front
// Accepts link events, keeps the sliding window state and timers, and
// turns each event into at most one command for the back.
// ----------------------------------------------------------------------------
module gbn_front import gbn_pkg::*; #(
   parameter int WINDOW_SIZE  = DEF_WINDOW_SIZE,
   parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          evt_valid,
   input  logic [1:0]                    evt_op,
   input  logic [SEQ_BITS-1:0]           evt_seq,
   input  logic [PORT_PAYLOAD_BITS-1:0]  evt_payload,
   input  logic                          csr_write,
   input  logic [AGE_BITS-1:0]           csr_data,
   output logic                          cmd_push,
   output cmd_type                       cmd_data
);

   localparam int STORE_BITS = (PAYLOAD_BITS < PORT_PAYLOAD_BITS) ?
                               PAYLOAD_BITS : PORT_PAYLOAD_BITS;

   logic [AGE_BITS-1:0]   timeout_ff;
   logic [SEQ_BITS-1:0]   next_send_ff,  next_send_in;
   logic [SEQ_BITS-1:0]   exp_ack_ff,    exp_ack_in;
   logic [COUNT_BITS-1:0] count_ff,      count_in;
   logic [SEQ_BITS-1:0]   last_rx_ff,    last_rx_in;
   logic [SEQ_BITS-1:0]   head_ff,       head_in;
   logic [AGE_BITS-1:0]   age_ff [SLOTS];
   logic [AGE_BITS-1:0]   age_in [SLOTS];
   logic [STORE_BITS-1:0] pay_ff [SLOTS];

   op_type                op;
   logic [SEQ_BITS-1:0]   ack_dist;
   logic [SEQ_BITS-1:0]   rel;
   logic [SEQ_BITS-1:0]   slot;
   logic                  pay_write;
   logic [SLOTS-1:0]      busy;
   logic [AGE_BITS-1:0]   aged [SLOTS];
   logic                  expired;

   assign op       = op_type'(evt_op);
   assign ack_dist = evt_seq - exp_ack_ff;
   assign slot     = head_ff + count_ff[SEQ_BITS-1:0];

   // Ages after one tick, and whether any outstanding frame has run out.
   always_comb begin
      expired = 1'b0;
      rel     = '0;
      for (int i = 0; i < SLOTS; i++) begin
         rel     = SEQ_BITS'(i) - head_ff;
         busy[i] = {1'b0, rel} < count_ff;
         aged[i] = (age_ff[i] == AGE_MAX) ? age_ff[i] : age_ff[i] + 1'b1;
         if (busy[i] && (aged[i] > timeout_ff)) begin
            expired = 1'b1;
         end
      end
   end

   always_comb begin
      next_send_in = next_send_ff;
      exp_ack_in   = exp_ack_ff;
      count_in     = count_ff;
      last_rx_in   = last_rx_ff;
      head_in      = head_ff;
      pay_write    = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         age_in[i] = age_ff[i];
      end
      cmd_push         = 1'b0;
      cmd_data.job     = JOB_SINGLE;
      cmd_data.kind    = KIND_SEND;
      cmd_data.seq     = evt_seq;
      cmd_data.payload = '0;
      cmd_data.head    = head_ff;
      cmd_data.count   = count_ff;
      for (int i = 0; i < SLOTS; i++) begin
         cmd_data.slots[i] = PORT_PAYLOAD_BITS'(pay_ff[i]);
      end
      if (evt_valid) begin
         case (op)
            OP_ACK: begin
               // A cumulative ack releases ack_dist+1 frames when it is plausible.
               if ((ack_dist != 2'd3) && ({1'b0, ack_dist} < count_ff)) begin
                  head_in    = head_ff + ack_dist + 1'b1;
                  exp_ack_in = exp_ack_ff + ack_dist + 1'b1;
                  count_in   = count_ff - {1'b0, ack_dist} - 1'b1;
               end else begin
                  cmd_push      = 1'b1;
                  cmd_data.kind = KIND_DISCARD;
               end
            end
            OP_DATA: begin
               if (evt_seq == last_rx_ff + 1'b1) begin
                  last_rx_in       = evt_seq;
                  cmd_push         = 1'b1;
                  cmd_data.job     = JOB_DELIVER;
                  cmd_data.payload = evt_payload;
               end else if (evt_seq == last_rx_ff) begin
                  cmd_push      = 1'b1;
                  cmd_data.kind = KIND_ACK;
               end
            end
            OP_SEND: begin
               cmd_push     = 1'b1;
               cmd_data.seq = next_send_ff;
               if (count_ff >= COUNT_BITS'(WINDOW_SIZE)) begin
                  cmd_data.kind = KIND_REFUSED;
               end else begin
                  pay_write        = 1'b1;
                  age_in[slot]     = '0;
                  cmd_data.kind    = KIND_SEND;
                  cmd_data.payload = PORT_PAYLOAD_BITS'(evt_payload[STORE_BITS-1:0]);
                  next_send_in     = next_send_ff + 1'b1;
                  count_in         = count_ff + 1'b1;
               end
            end
            OP_TICK: begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (busy[i]) begin
                     age_in[i] = expired ? '0 : aged[i];
                  end
               end
               if (expired) begin
                  cmd_push     = 1'b1;
                  cmd_data.job = JOB_RESEND;
                  cmd_data.seq = exp_ack_ff;
               end
            end
            default: begin
               cmd_push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         next_send_ff <= '0;
         exp_ack_ff   <= '0;
         count_ff     <= '0;
         last_rx_ff   <= LAST_RX_RESET;
         head_ff      <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            age_ff[i] <= '0;
         end
      end else begin
         if (csr_write) begin
            timeout_ff <= csr_data;
         end
         next_send_ff <= next_send_in;
         exp_ack_ff   <= exp_ack_in;
         count_ff     <= count_in;
         last_rx_ff   <= last_rx_in;
         head_ff      <= head_in;
         for (int i = 0; i < SLOTS; i++) begin
            age_ff[i] <= age_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pay_write) begin
         pay_ff[slot] <= evt_payload[STORE_BITS-1:0];
      end
   end

endmodule

### rtl/gbn_cmd_fifo.sv
// ----------------------------------------------------------------------------
// gbn_cmd_fifo
// Short command queue between the front and the back so that either side
// can stall without holding up the other.
// ----------------------------------------------------------------------------
module gbn_cmd_fifo import gbn_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   cmd_type                   entry_ff [CMD_DEPTH];
   logic [CMD_PTR_BITS-1:0]   wr_ptr_ff;
   logic [CMD_PTR_BITS-1:0]   rd_ptr_ff;
   logic [CMD_FILL_BITS-1:0]  fill_ff, fill_in;
   logic                      do_push;
   logic                      do_pop;

   assign full     = (fill_ff == CMD_FILL_BITS'(CMD_DEPTH));
   assign empty    = (fill_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/gbn_back.sv
// ----------------------------------------------------------------------------
// gbn_back
// Expands one command into its results, one a cycle while the consumer pops,
// into the result register that the consumer reads.
// ----------------------------------------------------------------------------
module gbn_back import gbn_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd_data,
   input  logic                          cmd_empty,
   output logic                          cmd_pop,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [2:0]                    rsp_kind,
   output logic [SEQ_BITS-1:0]           rsp_frame_seq,
   output logic [PORT_PAYLOAD_BITS-1:0]  rsp_frame_payload,
   output logic                          rsp_last
);

   logic [SEQ_BITS-1:0]           idx_ff, idx_in;
   logic                          out_valid_ff;
   kind_type                      kind_ff;
   logic [SEQ_BITS-1:0]           seq_ff;
   logic [PORT_PAYLOAD_BITS-1:0]  pay_ff;
   logic                          last_ff;

   kind_type                      res_kind;
   logic [SEQ_BITS-1:0]           res_seq;
   logic [PORT_PAYLOAD_BITS-1:0]  res_pay;
   logic                          res_last;
   logic [SEQ_BITS-1:0]           res_slot;
   logic                          load;
   logic                          fire;

   assign load     = !out_valid_ff || rsp_pop;
   assign fire     = load && !cmd_empty;
   assign cmd_pop  = fire && res_last;
   assign idx_in   = res_last ? '0 : idx_ff + 1'b1;
   assign res_slot = cmd_data.head + idx_ff;

   always_comb begin
      res_kind = cmd_data.kind;
      res_seq  = cmd_data.seq;
      res_pay  = cmd_data.payload;
      res_last = 1'b1;
      case (cmd_data.job)
         JOB_SINGLE: begin
            res_last = 1'b1;
         end
         JOB_DELIVER: begin
            // Payload goes up first, the ack for it follows.
            if (idx_ff == '0) begin
               res_kind = KIND_DELIVER;
               res_last = 1'b0;
            end else begin
               res_kind = KIND_ACK;
               res_pay  = '0;
            end
         end
         JOB_RESEND: begin
            res_kind = KIND_SEND;
            res_seq  = cmd_data.seq + idx_ff;
            res_pay  = cmd_data.slots[res_slot];
            res_last = (({1'b0, idx_ff} + 1'b1) == cmd_data.count);
         end
         default: begin
            res_last = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            out_valid_ff <= !cmd_empty;
         end
         if (fire) begin
            idx_ff <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         kind_ff <= res_kind;
         seq_ff  <= res_seq;
         pay_ff  <= res_pay;
         last_ff <= res_last;
      end
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_frame_seq     = seq_ff;
   assign rsp_frame_payload = pay_ff;
   assign rsp_last          = last_ff;

endmodule

### tb/sv/tb_go_back_n_link_endpoint.sv
// ----------------------------------------------------------------------------
// tb_go_back_n_link_endpoint
// Self-checking bench for the Go-Back-N link endpoint. Events are pushed
// through the request queue in bursts with random gaps, and a local model of
// the window predicts every result. The response side pops on its own stall
// pattern, and each result is compared field by field with the oldest
// prediction. Directed tests cover the receive path, a full window, every
// kind of ack and the timeout extremes. Seeded random traffic then runs
// under several timeout settings.
// ----------------------------------------------------------------------------
module tb_go_back_n_link_endpoint;
   import gbn_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 12;

   typedef struct packed {
      kind_type                     kind;
      logic [SEQ_BITS-1:0]          seq;
      logic [PORT_PAYLOAD_BITS-1:0] payload;
      logic                         last;
   } link_result_type;

   logic                         clock;
   logic                         reset             = 1'b1;
   logic                         req_push          = 1'b0;
   logic                         req_full;
   logic [1:0]                   req_op            = OP_ACK;
   logic [SEQ_BITS-1:0]          req_seq_num       = '0;
   logic [PORT_PAYLOAD_BITS-1:0] req_payload       = '0;
   logic                         rsp_empty;
   logic                         rsp_pop           = 1'b0;
   logic [2:0]                   rsp_kind;
   logic [SEQ_BITS-1:0]          rsp_frame_seq;
   logic [PORT_PAYLOAD_BITS-1:0] rsp_frame_payload;
   logic                         rsp_last;
   logic                         csr_valid         = 1'b0;
   logic                         csr_ready;
   logic [AGE_BITS-1:0]          csr_timeout_ticks = '0;

   // Local copy of the endpoint state.
   logic [SEQ_BITS-1:0]          tx_next_seq;
   logic [SEQ_BITS-1:0]          tx_ack_seq;
   logic [COUNT_BITS-1:0]        tx_outstanding;
   logic [SEQ_BITS-1:0]          rx_last_seq;
   logic [SEQ_BITS-1:0]          win_head;
   logic [PORT_PAYLOAD_BITS-1:0] win_payload [SLOTS];
   logic [AGE_BITS-1:0]          win_age [SLOTS];
   logic [AGE_BITS-1:0]          cfg_timeout;

   link_result_type pending_results [$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int burst_left     = 0;
   int pop_mode       = 0;
   int pop_mode_left  = 0;
   int stall_left     = 0;

   go_back_n_link_endpoint #(
      .WINDOW_SIZE  (DEF_WINDOW_SIZE),
      .PAYLOAD_BITS (DEF_PAYLOAD_BITS)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_op            (req_op),
      .req_seq_num       (req_seq_num),
      .req_payload       (req_payload),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_kind          (rsp_kind),
      .rsp_frame_seq     (rsp_frame_seq),
      .rsp_frame_payload (rsp_frame_payload),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_timeout_ticks (csr_timeout_ticks)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Watchdog expired after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Output is capped so that a broken design cannot flood the log.
   task automatic report_mismatch(input string msg);
      if (mismatch_count < 40)
         $display("ERROR (cycle %0d): %s", cycle_count, msg);
      mismatch_count++;
   endtask

   task automatic reset_link_state();
      tx_next_seq    = '0;
      tx_ack_seq     = '0;
      tx_outstanding = '0;
      rx_last_seq    = LAST_RX_RESET;
      win_head       = '0;
      cfg_timeout    = TIMEOUT_RESET;
      for (int i = 0; i < SLOTS; i++) begin
         win_payload[i] = '0;
         win_age[i]     = '0;
      end
   endtask

   // Works out the results of one accepted event and updates the local state.
   task automatic predict_link_event(input op_type op, input logic [SEQ_BITS-1:0] seq,
                                     input logic [PORT_PAYLOAD_BITS-1:0] pay);
      link_result_type     res [4];
      int                  n;
      logic [SEQ_BITS-1:0] ack_dist;
      logic [SEQ_BITS-1:0] idx;
      logic [SEQ_BITS-1:0] slot;
      logic [SEQ_BITS-1:0] in_order;
      logic                expired;
      n = 0;
      case (op)
         OP_ACK: begin
            ack_dist = seq - tx_ack_seq;
            if (ack_dist != 2'd3 && {1'b0, ack_dist} < tx_outstanding) begin
               win_head       = win_head + ack_dist + 2'd1;
               tx_ack_seq     = tx_ack_seq + ack_dist + 2'd1;
               tx_outstanding = tx_outstanding - {1'b0, ack_dist} - 3'd1;
            end else begin
               res[n] = '{KIND_DISCARD, seq, '0, 1'b0};
               n++;
            end
         end
         OP_DATA: begin
            in_order = rx_last_seq + 2'd1;
            if (seq == in_order) begin
               rx_last_seq = seq;
               res[0] = '{KIND_DELIVER, seq, pay, 1'b0};
               res[1] = '{KIND_ACK, seq, '0, 1'b0};
               n = 2;
            end else if (seq == rx_last_seq) begin
               res[0] = '{KIND_ACK, seq, '0, 1'b0};
               n = 1;
            end
         end
         OP_SEND: begin
            if (tx_outstanding >= DEF_WINDOW_SIZE) begin
               res[0] = '{KIND_REFUSED, tx_next_seq, '0, 1'b0};
            end else begin
               slot = win_head + tx_outstanding[SEQ_BITS-1:0];
               win_payload[slot] = pay;
               win_age[slot]     = '0;
               res[0] = '{KIND_SEND, tx_next_seq, pay, 1'b0};
               tx_next_seq    = tx_next_seq + 2'd1;
               tx_outstanding = tx_outstanding + 3'd1;
            end
            n = 1;
         end
         default: begin
            expired = 1'b0;
            for (int i = 0; i < tx_outstanding; i++) begin
               idx  = SEQ_BITS'(i);
               slot = win_head + idx;
               if (win_age[slot] != AGE_MAX)
                  win_age[slot] = win_age[slot] + 1'b1;
               if (win_age[slot] > cfg_timeout)
                  expired = 1'b1;
            end
            if (expired) begin
               for (int i = 0; i < tx_outstanding; i++) begin
                  idx  = SEQ_BITS'(i);
                  slot = win_head + idx;
                  res[n] = '{KIND_SEND, tx_ack_seq + idx, win_payload[slot], 1'b0};
                  win_age[slot] = '0;
                  n++;
               end
            end
         end
      endcase
      for (int i = 0; i < n; i++) begin
         res[i].last = (i == n - 1);
         pending_results = {pending_results, res[i]};
      end
   endtask

   // Pushes one event, idling between bursts, and predicts it on transfer.
   task automatic send_event(input op_type op, input logic [SEQ_BITS-1:0] seq,
                             input logic [PORT_PAYLOAD_BITS-1:0] pay);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_push <= 1'b0;
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      @(negedge clock);
      req_push    <= 1'b1;
      req_op      <= op;
      req_seq_num <= seq;
      req_payload <= pay;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      predict_link_event(op, seq, pay);
   endtask

   task automatic wait_results_drained();
      @(negedge clock);
      req_push <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      // Events without results may still be in flight inside the block.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [AGE_BITS-1:0] value);
      wait_results_drained();
      @(negedge clock);
      csr_valid         <= 1'b1;
      csr_timeout_ticks <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      cfg_timeout = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Response side: phases of steady popping, random popping and long stalls.
   always @(negedge clock) begin
      if (pop_mode_left == 0) begin
         pop_mode      = $urandom_range(0, 2);
         pop_mode_left = $urandom_range(16, 96);
      end else begin
         pop_mode_left--;
      end
      case (pop_mode)
         0: rsp_pop <= 1'b1;
         1: rsp_pop <= ($urandom_range(0, 1) == 1);
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_pop <= 1'b0;
            end else begin
               rsp_pop <= 1'b1;
               if ($urandom_range(0, 3) == 0)
                  stall_left = $urandom_range(1, 10);
            end
         end
      endcase
   end

   always @(posedge clock) begin : check_results
      link_result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d seq %0d payload %h",
                                      rsp_kind, rsp_frame_seq, rsp_frame_payload));
         end else begin
            want = pending_results.pop_front();
            if (rsp_kind !== want.kind)
               report_mismatch($sformatf("kind %0d, expected %0d", rsp_kind, want.kind));
            if (rsp_frame_seq !== want.seq)
               report_mismatch($sformatf("frame_seq %0d, expected %0d",
                                         rsp_frame_seq, want.seq));
            if (rsp_frame_payload !== want.payload)
               report_mismatch($sformatf("frame_payload %h, expected %h",
                                         rsp_frame_payload, want.payload));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %0b, expected %0b", rsp_last, want.last));
         end
      end
   end

   // Runs with the timeout still at its reset value.
   task automatic test_receive_path();
      send_event(OP_TICK, 2'd0, '0);
      send_event(OP_DATA, 2'd0, 32'hFFFF_FFFF);
      send_event(OP_DATA, 2'd0, '0);
      send_event(OP_DATA, 2'd2, $urandom);
      send_event(OP_DATA, 2'd1, '0);
      send_event(OP_DATA, 2'd2, $urandom);
   endtask

   task automatic test_send_window();
      send_event(OP_SEND, 2'd3, '0);
      send_event(OP_SEND, 2'd0, 32'hFFFF_FFFF);
      send_event(OP_SEND, 2'd1, $urandom);
      send_event(OP_SEND, 2'd2, $urandom);
      send_event(OP_SEND, 2'd3, $urandom);
      send_event(OP_TICK, 2'd0, '0);
   endtask

   // Starts with a full window: an ack three ahead, an in-range ack, a stale
   // one, a release of the rest and an ack with nothing outstanding.
   task automatic test_ack_release();
      send_event(OP_ACK, tx_ack_seq + 2'd3, $urandom);
      send_event(OP_ACK, tx_ack_seq, '0);
      send_event(OP_ACK, tx_ack_seq + 2'd3, '0);
      send_event(OP_ACK, tx_ack_seq + 2'd2, '0);
      send_event(OP_ACK, tx_ack_seq, 32'hFFFF_FFFF);
   endtask

   task automatic test_timeout_extremes();
      write_timeout('0);
      send_event(OP_SEND, 2'd0, $urandom);
      send_event(OP_SEND, 2'd1, $urandom);
      send_event(OP_TICK, 2'd3, $urandom);
      write_timeout(24'd2);
      repeat (3) send_event(OP_TICK, 2'd0, '0);
      write_timeout(AGE_MAX);
      send_event(OP_SEND, 2'd2, $urandom);
      send_event(OP_SEND, 2'd3, $urandom);
      repeat (2) send_event(OP_TICK, 2'd1, '0);
   endtask

   // Mostly well-formed traffic built from the current window state, with
   // random acks and frames mixed in. Halfway through, the sender holds off
   // until every result has come back.
   task automatic test_random_traffic(input int items, input logic [AGE_BITS-1:0] timeout);
      op_type              op;
      logic [SEQ_BITS-1:0] seq;
      logic [SEQ_BITS-1:0] dsel;
      int                  pick;
      int                  span;
      write_timeout(timeout);
      for (int k = 0; k < items; k++) begin
         if (k == items / 2)
            wait_results_drained();
         pick = $urandom_range(0, 99);
         seq  = SEQ_BITS'($urandom);
         if (pick < 30) begin
            op = OP_SEND;
         end else if (pick < 55) begin
            op = OP_ACK;
            if (tx_outstanding != 0 && $urandom_range(0, 9) < 7) begin
               span = (tx_outstanding > 3) ? 3 : tx_outstanding;
               dsel = SEQ_BITS'($urandom_range(0, span - 1));
               seq  = tx_ack_seq + dsel;
            end
         end else if (pick < 80) begin
            op   = OP_DATA;
            pick = $urandom_range(0, 9);
            if (pick < 6)
               seq = rx_last_seq + 2'd1;
            else if (pick < 8)
               seq = rx_last_seq;
         end else begin
            op = OP_TICK;
         end
         send_event(op, seq, $urandom);
      end
   endtask

   initial begin
      reset_link_state();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_receive_path();
      test_send_window();
      test_ack_release();
      test_timeout_extremes();
      test_random_traffic(54, 24'd1);
      test_random_traffic(54, 24'd3);
      test_random_traffic(54, AGE_BITS'($urandom_range(0, 10)));
      test_random_traffic(54, AGE_BITS'($urandom_range(0, 24'hFF_FFFF)));
      test_random_traffic(54, 24'd2);

      wait_results_drained();
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
